// ===== rtl/mmc_pkg.sv =====
// shared types and constants for the multirotor mixing coefficient core
`default_nettype none

package mmc_pkg;

  typedef struct packed {
    logic [2:0]         motor_id;
    logic [31:0]        kv_rating;
    logic [31:0]        supply_voltage;
    logic [31:0]        signal_max;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] azimuth_angle;
    logic [31:0]        thrust_coef;
    logic [31:0]        drag_coef;
    logic               spins_positive;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [2:0]         motor_echo;
    logic signed [47:0] coef_0;
    logic signed [47:0] coef_1;
    logic signed [47:0] coef_2;
    logic signed [47:0] coef_3;
    logic signed [47:0] coef_4;
    logic signed [47:0] coef_5;
    logic [2:0]         coef_count;
    logic               divide_error;
  } out_t;

  localparam int MAG_W = 60;

  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic signed [MAG_W:0] fx_t;

  localparam mag_t SAT_LIM = {MAG_W{1'b1}};

  localparam int NUM_COORD = 6;
  localparam logic [NUM_COORD-1:0] COORD_EN_RESET = 6'h3f;
  localparam logic REG_COORD_ENABLE = 1'b0;

  localparam logic signed [47:0] OUT_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] OUT_MIN = {1'b1, {47{1'b0}}};

  localparam int Q30 = 30;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [30:0] SIN_C9 = 31'd172273;
  localparam int SIN_STEPS = 4;
  localparam logic [30:0] SIN_COEF [SIN_STEPS] = '{
    31'd5026994, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  function automatic mag_t fx_mag(input fx_t v);
    fx_t n;
    n = -v;
    return v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mmc_mulshr.sv =====
// three-stage magnitude multiply with shift, truncation and saturation
`default_nettype none

module mmc_mulshr #(
  parameter int SH = 16
) (
  input  logic          clk,
  input  logic          en,
  input  mmc_pkg::mag_t a_mag,
  input  mmc_pkg::mag_t b_mag,
  input  logic          neg,
  output mmc_pkg::fx_t  res
);
  import mmc_pkg::*;

  localparam int HALF = MAG_W / 2;
  localparam int PW   = 2 * MAG_W;

  logic [2*HALF-1:0] pp_r [4];
  logic              neg_a_r;
  logic              neg_b_r;
  logic [PW-1:0]     prod_r;
  logic [PW-1:0]     shifted;
  mag_t              mag;
  fx_t               res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= a_mag[HALF-1:0] * b_mag[HALF-1:0];
      pp_r[1] <= a_mag[HALF-1:0] * b_mag[MAG_W-1:HALF];
      pp_r[2] <= a_mag[MAG_W-1:HALF] * b_mag[HALF-1:0];
      pp_r[3] <= a_mag[MAG_W-1:HALF] * b_mag[MAG_W-1:HALF];
      neg_a_r <= neg;
      prod_r  <= {pp_r[3], pp_r[0]} + (PW'(pp_r[1]) << HALF) + (PW'(pp_r[2]) << HALF);
      neg_b_r <= neg_a_r;
      res_r   <= neg_b_r ? -fx_t'({1'b0, mag}) : fx_t'({1'b0, mag});
    end
  end

  assign shifted = prod_r >> SH;
  assign mag     = (|shifted[PW-1:MAG_W]) ? SAT_LIM : shifted[MAG_W-1:0];
  assign res     = res_r;

endmodule

`default_nettype wire

// ===== rtl/mmc_sine.sv =====
// seven-stage polynomial sine of a 16-bit turn fraction, q.30 result
`default_nettype none

module mmc_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [31:0] sine
);
  import mmc_pkg::*;

  logic [30:0]        z_r   [SIN_STEPS+2];
  logic               neg_r [SIN_STEPS+2];
  logic [30:0]        z2_r  [1:SIN_STEPS];
  logic [30:0]        p_r   [2:SIN_STEPS+1];
  logic [14:0]        k;
  logic [61:0]        zz;
  logic [61:0]        zp;
  logic [31:0]        s;
  logic [31:0]        s_cl;
  logic signed [31:0] sine_r;

  assign k  = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign zz = z_r[0] * z_r[0];

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= {k, 16'b0};
      neg_r[0] <= angle[15];
      z_r[1]   <= z_r[0];
      neg_r[1] <= neg_r[0];
      z2_r[1]  <= zz[Q30+30:Q30];
    end
  end

  for (genvar st = 0; st < SIN_STEPS; st++) begin : g_horner
    logic [30:0] p_in;
    logic [61:0] prod;
    logic [31:0] diff;
    if (st == 0) begin : g_first
      assign p_in = SIN_C9;
    end else begin : g_next
      assign p_in = p_r[st+1];
    end
    assign prod = z2_r[st+1] * p_in;
    assign diff = {1'b0, SIN_COEF[st]} - prod[Q30+31:Q30];
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[st+2]   <= diff[30:0];
        z_r[st+2]   <= z_r[st+1];
        neg_r[st+2] <= neg_r[st+1];
      end
    end
    if (st < SIN_STEPS - 1) begin : g_z2
      always_ff @(posedge clk) begin
        if (en) begin
          z2_r[st+2] <= z2_r[st+1];
        end
      end
    end
  end

  assign zp   = z_r[SIN_STEPS+1] * p_r[SIN_STEPS+1];
  assign s    = zp[Q30+31:Q30];
  assign s_cl = (s > {1'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : s;

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r <= neg_r[SIN_STEPS+1] ? -signed'(s_cl) : signed'(s_cl);
    end
  end

  assign sine = sine_r;

endmodule

`default_nettype wire

// ===== rtl/multirotor_mixing_coefficients_core.sv =====
// top level of the multirotor mixing coefficient core
// Takes one motor description per cycle and returns its mixing-matrix column from a
// registered output; one request enters every cycle while the result side keeps up.
// Most of the pipeline is the 64-stage restoring divider that forms the quotient
// kv*voltage/signal_max, one quotient bit per stage, followed by four three-stage
// multiply rows. A stall on the result side freezes the whole pipeline, nothing is
// dropped or repeated.
`default_nettype none

module multirotor_mixing_coefficients_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mmc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mmc_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import mmc_pkg::*;

  localparam int DIV_BITS   = 64;
  localparam int MUL_LAT    = 3;
  localparam int SIN_LAT    = 7;
  localparam int ST_Q       = 1 + DIV_BITS;
  localparam int ST_R2      = ST_Q + MUL_LAT;
  localparam int ST_TR2     = ST_R2 + MUL_LAT;
  localparam int ST_TRIG_IN = ST_TR2 - MUL_LAT - SIN_LAT;
  localparam int ST_TC      = ST_TR2 + MUL_LAT;
  localparam int LAST       = ST_TC + MUL_LAT;
  localparam int PA [NUM_COORD] = '{1, 2, 2, 0, 0, 1};
  localparam int TB [NUM_COORD] = '{2, 1, 0, 2, 1, 0};

  typedef struct packed {
    logic [2:0]       motor_id;
    logic             divide_error;
    logic             spins_positive;
    logic [31:0]      signal_max;
    logic [15:0]      tilt_angle;
    logic [15:0]      azimuth_angle;
    logic [31:0]      thrust_coef;
    logic [31:0]      drag_coef;
    logic [2:0][31:0] pos;
  } side_t;

  logic                 en;
  logic [LAST:1]        valid_r;
  side_t                side_in;
  side_t                side_r [1:LAST];
  logic [63:0]          prod_r;
  logic [31:0]          div_rem_r [DIV_BITS];
  logic [63:0]          div_nq_r  [DIV_BITS];
  logic [63:0]          quot;
  mag_t                 r_mag;
  fx_t                  r2;
  fx_t                  tr2;
  fx_t                  cr2;
  logic signed [31:0]   trig [4];
  logic [15:0]          trig_ang [4];
  logic signed [31:0]   ct_d_r [MUL_LAT];
  fx_t                  dir [3];
  fx_t                  thr [3];
  fx_t                  trq [3];
  fx_t                  cs  [3];
  fx_t                  thr_d_r [MUL_LAT][3];
  fx_t                  cs_d_r  [MUL_LAT][3];
  fx_t                  mom [NUM_COORD];
  logic signed [63:0]   coord [NUM_COORD];
  logic signed [47:0]   slot  [NUM_COORD];
  logic [2:0]           n;
  logic [NUM_COORD-1:0] coord_en_r;
  logic                 out_valid_r;
  out_t                 out_nxt;
  out_t                 out_data_r;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (v < 64'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return v[47:0];
  endfunction

  function automatic fx_t ext32(input logic signed [31:0] v);
    return fx_t'(v);
  endfunction

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_en_r <= COORD_EN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_COORD_ENABLE) begin
      coord_en_r <= pwdata[NUM_COORD-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COORD_ENABLE) ? {26'b0, coord_en_r} : '0;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    side_in.motor_id       = in_data.motor_id;
    side_in.divide_error   = (in_data.signal_max == '0);
    side_in.spins_positive = in_data.spins_positive;
    side_in.signal_max     = in_data.signal_max;
    side_in.tilt_angle     = in_data.tilt_angle;
    side_in.azimuth_angle  = in_data.azimuth_angle;
    side_in.thrust_coef    = in_data.thrust_coef;
    side_in.drag_coef      = in_data.drag_coef;
    side_in.pos[0]         = in_data.pos_x;
    side_in.pos[1]         = in_data.pos_y;
    side_in.pos[2]         = in_data.pos_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= side_in;
      for (int i = 2; i <= LAST; i++) begin
        side_r[i] <= side_r[i-1];
      end
      prod_r <= in_data.kv_rating * in_data.supply_voltage;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [31:0] rem_in;
    logic [63:0] nq_in;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = prod_r;
    end else begin : g_next
      assign rem_in = div_rem_r[j-1];
      assign nq_in  = div_nq_r[j-1];
    end
    assign trial = {rem_in, nq_in[63]};
    assign diff  = trial - {1'b0, side_r[j+1].signal_max};
    assign ge    = !diff[32];
    always_ff @(posedge clk) begin
      if (en) begin
        div_rem_r[j] <= ge ? diff[31:0] : trial[31:0];
        div_nq_r[j]  <= {nq_in[62:0], ge};
      end
    end
  end

  assign quot  = div_nq_r[DIV_BITS-1];
  assign r_mag = (|quot[63:MAG_W]) ? SAT_LIM : quot[MAG_W-1:0];

  mmc_mulshr #(.SH(16)) u_r2 (
    .clk(clk), .en(en), .a_mag(r_mag), .b_mag(r_mag), .neg(1'b0), .res(r2)
  );

  mmc_mulshr #(.SH(40)) u_tr2 (
    .clk(clk), .en(en), .a_mag(MAG_W'(side_r[ST_R2].thrust_coef)), .b_mag(r2[MAG_W-1:0]),
    .neg(1'b0), .res(tr2)
  );

  mmc_mulshr #(.SH(40)) u_cr2 (
    .clk(clk), .en(en), .a_mag(MAG_W'(side_r[ST_R2].drag_coef)), .b_mag(r2[MAG_W-1:0]),
    .neg(1'b0), .res(cr2)
  );

  // sin tilt, cos tilt, sin azimuth, cos azimuth
  assign trig_ang[0] = side_r[ST_TRIG_IN].tilt_angle;
  assign trig_ang[1] = side_r[ST_TRIG_IN].tilt_angle + QUARTER_TURN;
  assign trig_ang[2] = side_r[ST_TRIG_IN].azimuth_angle;
  assign trig_ang[3] = side_r[ST_TRIG_IN].azimuth_angle + QUARTER_TURN;

  for (genvar t = 0; t < 4; t++) begin : g_trig
    mmc_sine u_sine (.clk(clk), .en(en), .angle(trig_ang[t]), .sine(trig[t]));
  end

  mmc_mulshr #(.SH(Q30)) u_rx (
    .clk(clk), .en(en), .a_mag(fx_mag(ext32(trig[3]))), .b_mag(fx_mag(ext32(trig[0]))),
    .neg(trig[3][31] ^ trig[0][31]), .res(dir[0])
  );

  mmc_mulshr #(.SH(Q30)) u_ry (
    .clk(clk), .en(en), .a_mag(fx_mag(ext32(trig[2]))), .b_mag(fx_mag(ext32(trig[0]))),
    .neg(trig[2][31] ^ trig[0][31]), .res(dir[1])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ct_d_r[0] <= trig[1];
      for (int i = 1; i < MUL_LAT; i++) begin
        ct_d_r[i] <= ct_d_r[i-1];
      end
    end
  end

  assign dir[2] = ext32(ct_d_r[MUL_LAT-1]);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    mmc_mulshr #(.SH(Q30)) u_thr (
      .clk(clk), .en(en), .a_mag(fx_mag(dir[a])), .b_mag(tr2[MAG_W-1:0]),
      .neg(dir[a][MAG_W]), .res(thr[a])
    );
    mmc_mulshr #(.SH(Q30)) u_trq (
      .clk(clk), .en(en), .a_mag(fx_mag(dir[a])), .b_mag(cr2[MAG_W-1:0]),
      .neg(dir[a][MAG_W]), .res(trq[a])
    );
    if (a == 1) begin : g_pitch
      assign cs[a] = side_r[ST_TC].spins_positive ? trq[a] : -trq[a];
    end else begin : g_roll_yaw
      assign cs[a] = side_r[ST_TC].spins_positive ? -trq[a] : trq[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      thr_d_r[0] <= thr;
      cs_d_r[0]  <= cs;
      for (int i = 1; i < MUL_LAT; i++) begin
        thr_d_r[i] <= thr_d_r[i-1];
        cs_d_r[i]  <= cs_d_r[i-1];
      end
    end
  end

  // position cross products
  for (genvar m = 0; m < NUM_COORD; m++) begin : g_moment
    mmc_mulshr #(.SH(16)) u_mom (
      .clk(clk), .en(en), .a_mag(fx_mag(ext32(side_r[ST_TC].pos[PA[m]]))),
      .b_mag(fx_mag(thr[TB[m]])),
      .neg(side_r[ST_TC].pos[PA[m]][31] ^ thr[TB[m]][MAG_W]), .res(mom[m])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coord[i]   = 64'(thr_d_r[MUL_LAT-1][i]);
      coord[i+3] = 64'(cs_d_r[MUL_LAT-1][i]) + 64'(mom[2*i]) - 64'(mom[2*i+1]);
    end
    n = '0;
    for (int i = 0; i < NUM_COORD; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < NUM_COORD; i++) begin
      if (coord_en_r[i]) begin
        slot[n] = side_r[LAST].divide_error ? '0 : sat48(coord[i]);
        n = n + 3'd1;
      end
    end
    out_nxt.motor_echo   = side_r[LAST].motor_id;
    out_nxt.coef_0       = slot[0];
    out_nxt.coef_1       = slot[1];
    out_nxt.coef_2       = slot[2];
    out_nxt.coef_3       = slot[3];
    out_nxt.coef_4       = slot[4];
    out_nxt.coef_5       = slot[5];
    out_nxt.coef_count   = n;
    out_nxt.divide_error = side_r[LAST].divide_error;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/mmc_checker.sv =====
// port-level checks for the multirotor mixing coefficient core, with bind
`default_nettype none

module mmc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input mmc_pkg::out_t out_data
);
  import mmc_pkg::*;

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_error |->
      out_data.coef_0 == '0 && out_data.coef_3 == '0 && out_data.coef_5 == '0)
    else $error("divide error with nonzero coefficient");

  a_unused_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coef_count != 3'd6 |-> out_data.coef_5 == '0)
    else $error("unused coefficient slot not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while pipeline frozen");

endmodule

bind multirotor_mixing_coefficients_core mmc_checker u_mmc_checker (.*);

`default_nettype wire
